@@ rtl/apm_pkg.sv @@
`timescale 1ns / 1ps

package apm_pkg;

	localparam int CHAR_W = 8;
	localparam int CODE_W = 6;
	localparam int PAT_W  = 60;
	localparam int LEN_W  = 4;
	localparam int MODE_W = 3;
	localparam int CNT_W  = 6;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int REG_W  = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_PREFIX = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SUFFIX = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BOTH   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INSIDE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RUN    = 3'd4;

	localparam logic [REG_W-1:0] REG_MATCH_MODE     = 3'd0;
	localparam logic [REG_W-1:0] REG_FOLD_CASE      = 3'd1;
	localparam logic [REG_W-1:0] REG_FIRST_PATTERN  = 3'd2;
	localparam logic [REG_W-1:0] REG_FIRST_LENGTH   = 3'd3;
	localparam logic [REG_W-1:0] REG_SECOND_PATTERN = 3'd4;
	localparam logic [REG_W-1:0] REG_SECOND_LENGTH  = 3'd5;
	localparam logic [REG_W-1:0] REG_RUN_LENGTH     = 3'd6;

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_CASE_OFS = 8'h20;

	localparam int B58_LEN = 58;
	// first character sits in the top byte
	localparam logic [CHAR_W*B58_LEN-1:0] B58_ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
		input logic en);
		if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			return c + CH_CASE_OFS;
		end
		return c;
	endfunction

	function automatic logic code_eq(input logic [CODE_W-1:0] code,
		input logic [CHAR_W-1:0] c, input logic en);
		logic [CHAR_W-1:0] pc;
		pc = '0;
		if (int'(code) >= B58_LEN) begin
			return 1'b0;
		end
		pc = B58_ALPHABET[(B58_LEN - 1 - int'(code)) * CHAR_W +: CHAR_W];
		return fold_char(pc, en) == fold_char(c, en);
	endfunction

endpackage

@@ rtl/apm_if.sv @@
`timescale 1ns / 1ps

interface apm_in_if import apm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] addr_char;
	logic              is_last;

	modport source (output valid, output addr_char, output is_last, input ready);
	modport sink   (input valid, input addr_char, input is_last, output ready);
endinterface

interface apm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink   (input valid, input matched, output ready);
endinterface

@@ rtl/address_pattern_matcher_core.sv @@
`timescale 1ns / 1ps

// Vanity address matcher. Takes one address character per clock on char_stream
// and, for the beat flagged is_last, registers one match bit into the result
// queue that feeds match_stream. Every character is folded into the window,
// length counter and sticky flags in the cycle it is accepted, so the sustained
// rate is one character per cycle; a two-entry result queue sets ready, which
// drops only when two results are waiting. Registers sit on a 64-bit APB port
// at byte address 8*index; a write applies from the next accepted character on.
module address_pattern_matcher_core import apm_pkg::*; #(
	parameter int MAX_PATTERN  = 10,
	parameter int WINDOW_DEPTH = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	apm_in_if.sink            char_stream,
	apm_out_if.source         match_stream,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
	localparam logic [LEN_W-1:0] MAXP = LEN_W'(MAX_PATTERN);
	localparam logic [LEN_W:0] WDEPTH = (LEN_W + 1)'(WINDOW_DEPTH);

	// configuration
	logic [MODE_W-1:0] match_mode_q;
	logic              fold_case_q;
	logic [PAT_W-1:0]  first_pattern_q;
	logic [LEN_W-1:0]  first_length_q;
	logic [PAT_W-1:0]  second_pattern_q;
	logic [LEN_W-1:0]  second_length_q;
	logic [LEN_W-1:0]  run_length_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q     <= MODE_PREFIX;
			fold_case_q      <= 1'b0;
			first_pattern_q  <= '0;
			first_length_q   <= LEN_W'(1);
			second_pattern_q <= '0;
			second_length_q  <= LEN_W'(1);
			run_length_q     <= LEN_W'(3);
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_W-1:3])
				REG_MATCH_MODE:     match_mode_q     <= pwdata[MODE_W-1:0];
				REG_FOLD_CASE:      fold_case_q      <= pwdata[0];
				REG_FIRST_PATTERN:  first_pattern_q  <= pwdata[PAT_W-1:0];
				REG_FIRST_LENGTH:   first_length_q   <= pwdata[LEN_W-1:0];
				REG_SECOND_PATTERN: second_pattern_q <= pwdata[PAT_W-1:0];
				REG_SECOND_LENGTH:  second_length_q  <= pwdata[LEN_W-1:0];
				REG_RUN_LENGTH:     run_length_q     <= pwdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:3])
			REG_MATCH_MODE:     prdata = DATA_W'(match_mode_q);
			REG_FOLD_CASE:      prdata = DATA_W'(fold_case_q);
			REG_FIRST_PATTERN:  prdata = DATA_W'(first_pattern_q);
			REG_FIRST_LENGTH:   prdata = DATA_W'(first_length_q);
			REG_SECOND_PATTERN: prdata = DATA_W'(second_pattern_q);
			REG_SECOND_LENGTH:  prdata = DATA_W'(second_length_q);
			REG_RUN_LENGTH:     prdata = DATA_W'(run_length_q);
			default:            prdata = '0;
		endcase
	end

	// per-address state
	logic [CHAR_W-1:0] win_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic              head_ok_q;
	logic              found_q;

	// result queue
	logic [1:0] rq_cnt_q;
	logic       rq_data0_q;
	logic       rq_data1_q;

	logic acc, push, pop;
	assign char_stream.ready = (rq_cnt_q != 2'd2);
	assign acc  = char_stream.valid && char_stream.ready;
	assign push = acc && char_stream.is_last;
	assign pop  = match_stream.valid && match_stream.ready;
	assign match_stream.valid   = (rq_cnt_q != 2'd0);
	assign match_stream.matched = rq_data0_q;

	logic [LEN_W-1:0]  l1, l2;
	logic [LEN_W:0]    run_n;
	logic [CHAR_W-1:0] win_n [WINDOW_DEPTH];
	logic [CNT_W-1:0]  count_n;
	logic              head_ok_n, found_n;
	logic              first_hit, second_hit, run_hit, pre, m;
	logic [CHAR_W-1:0] sel;

	always_comb begin
		l1 = (first_length_q > MAXP) ? MAXP : first_length_q;
		l2 = (second_length_q > MAXP) ? MAXP : second_length_q;
		run_n = ({1'b0, run_length_q} > WDEPTH) ? WDEPTH : {1'b0, run_length_q};

		// leading characters checked at their own position
		head_ok_n = head_ok_q;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (count_q == CNT_W'(i) && CNT_W'(i) < CNT_W'(l1) &&
				!code_eq(first_pattern_q[CODE_W*i +: CODE_W], char_stream.addr_char,
					fold_case_q)) begin
				head_ok_n = 1'b0;
			end
		end

		win_n[0] = char_stream.addr_char;
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			win_n[i] = win_q[i-1];
		end
		count_n = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);

		// pattern code i lines up with window slot len-1-i
		first_hit  = (count_n >= CNT_W'(l1));
		second_hit = (count_n >= CNT_W'(l2));
		sel = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < int'(l1)) begin
				sel = win_n[WIN_IDX_W'(int'(l1) - 1 - i)];
				if (!code_eq(first_pattern_q[CODE_W*i +: CODE_W], sel, fold_case_q)) begin
					first_hit = 1'b0;
				end
			end
			if (i < int'(l2)) begin
				sel = win_n[WIN_IDX_W'(int'(l2) - 1 - i)];
				if (!code_eq(second_pattern_q[CODE_W*i +: CODE_W], sel, fold_case_q)) begin
					second_hit = 1'b0;
				end
			end
		end
		found_n = found_q || (l1 != '0 && first_hit);

		run_hit = (run_n > (LEN_W + 1)'(1)) && (count_n >= CNT_W'(run_n));
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			if (i < int'(run_n) && win_n[i] != win_n[0]) begin
				run_hit = 1'b0;
			end
		end

		pre = head_ok_n && (count_n >= CNT_W'(l1));
		unique case (match_mode_q)
			MODE_PREFIX: m = pre;
			MODE_SUFFIX: m = second_hit;
			MODE_BOTH:   m = pre && second_hit;
			MODE_INSIDE: m = (l1 == '0) || found_n;
			MODE_RUN:    m = run_hit;
			default:     m = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			count_q   <= '0;
			head_ok_q <= 1'b1;
			found_q   <= 1'b0;
		end else if (acc) begin
			if (char_stream.is_last) begin
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					win_q[i] <= '0;
				end
				count_q   <= '0;
				head_ok_q <= 1'b1;
				found_q   <= 1'b0;
			end else begin
				win_q     <= win_n;
				count_q   <= count_n;
				head_ok_q <= head_ok_n;
				found_q   <= found_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_cnt_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				rq_cnt_q <= rq_cnt_q + 2'd1;
			end else if (pop && !push) begin
				rq_cnt_q <= rq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (rq_cnt_q == 2'd0) begin
				rq_data0_q <= m;
			end else begin
				rq_data1_q <= m;
			end
		end else if (pop && !push) begin
			rq_data0_q <= rq_data1_q;
		end else if (push && pop) begin
			if (rq_cnt_q == 2'd1) begin
				rq_data0_q <= m;
			end else begin
				rq_data0_q <= rq_data1_q;
				rq_data1_q <= m;
			end
		end
	end

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q != 2'd3)
		else $error("result queue overflow");

	a_no_result_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !char_stream.is_last && !pop) |=> $stable(rq_cnt_q))
		else $error("result created without a last beat");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && char_stream.is_last) |=> (count_q == '0 && head_ok_q && !found_q))
		else $error("address state not cleared after last beat");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (rq_cnt_q == $past(rq_cnt_q) - 2'd1))
		else $error("result queue count slip on pop");

endmodule
